@@ hdl/ffha_pkg.sv @@
// shared types, codes and sizing constants for the first-fit heap allocator
// no dependencies; used by ffha_table, first_fit_heap_allocator, ffha_checker and testbench
`default_nettype none
package ffha_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int PAGE_BYTES_DEF   = 4096;

  localparam int ADDR_W   = 48;
  localparam int SIZE_W   = 32;
  localparam int PAGES_W  = 21;
  localparam int ACC_W    = 50;  // unwrapped header address, blocks never reach 2^50
  localparam int DIV_W    = 51;  // end - limit + page - 1
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 64;

  localparam logic [ADDR_W-1:0]  HEAP_BASE_RST = 48'h0000_4000_0000;
  localparam logic [PAGES_W-1:0] PAGES_SAT     = 21'd1048576;
  localparam logic [PADDR_W-1:0] ADDR_HEAP_BASE = 4'd0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_SCAN_RD,
    S_A_SCAN_EV,
    S_A_SHIFT_RD,
    S_A_SHIFT_EV,
    S_A_SPLIT,
    S_A_SPLIT2,
    S_A_APPEND,
    S_F_SCAN_RD,
    S_F_SCAN_EV,
    S_F_MRG_RD,
    S_F_MRG_EV,
    S_F_MRG_END,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

@@ hdl/ffha_table.sv @@
// block table memory: one write port, one read port, registered read data
// depends on ffha_pkg for the entry type
`default_nettype none
module ffha_table #(
  parameter int DEPTH = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire                 clk,
  input  wire                 we,
  input  wire [IDX_W-1:0]     waddr,
  input  ffha_pkg::ent_t      wdata,
  input  wire [IDX_W-1:0]     raddr,
  output ffha_pkg::ent_t      rdata
);

  ffha_pkg::ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/first_fit_heap_allocator.sv @@
// first-fit heap allocator: each transaction scans the block table, a read and an evaluate state per entry;
// a split also shifts the later entries up, a found free also rewalks the whole table to coalesce;
// zero or oversized requests and zero payload addresses are refused without a table walk
// one transaction at a time, next accepted the cycle after the result is registered
// reset (rst_n, synchronous) clears count, heap base/limit and out_valid; table not cleared
`default_nettype none
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int PAGE_BYTES   = ffha_pkg::PAGE_BYTES_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            in_op,
  input  wire [31:0]                     in_request_bytes,
  input  wire [ffha_pkg::ADDR_W-1:0]     in_payload_address,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [ffha_pkg::ADDR_W-1:0]    out_block_address,
  output logic [1:0]                     out_status,
  output logic [ffha_pkg::PAGES_W-1:0]   out_pages_added,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [ffha_pkg::PADDR_W-1:0]    paddr,
  input  wire [ffha_pkg::PDATA_W-1:0]    pwdata,
  output logic [ffha_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int AW    = ffha_pkg::ADDR_W;
  localparam int SW    = ffha_pkg::SIZE_W;
  // page size must be a power of two (the block does not check it), so the page count is a shift
  localparam int PG_SH = $clog2(PAGE_BYTES);

  localparam logic [ffha_pkg::ACC_W-1:0] HDR_A  = ffha_pkg::ACC_W'(HEADER_BYTES);
  localparam logic [SW+1:0]              HDR_S  = (SW+2)'(HEADER_BYTES);
  localparam logic [SW+1:0]              MAX32  = (SW+2)'(64'hFFFF_FFFF);
  localparam logic [ffha_pkg::DIV_W-1:0] PG_LOW = ffha_pkg::DIV_W'(PAGE_BYTES - 1);
  localparam logic [CNT_W-1:0]           CNT_MAX = CNT_W'(MAX_BLOCKS);

  ffha_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]              base_r, base_nxt;
  logic [AW-1:0]              limit_r, limit_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [CNT_W-1:0]           idx_r, idx_nxt;
  logic [CNT_W-1:0]           hit_r, hit_nxt;
  logic [CNT_W-1:0]           wp_r, wp_nxt;
  logic [ffha_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [SW-1:0]              need_r, need_nxt;
  logic [SW-1:0]              have_r, have_nxt;
  logic [AW-1:0]              faddr_r, faddr_nxt;
  ffha_pkg::ent_t             held_r, held_nxt;
  logic                       hv_r, hv_nxt;
  logic                       grow_r, grow_nxt;
  logic [ffha_pkg::DIV_W-1:0] nq_r, nq_nxt;
  logic [AW-1:0]              res_addr_r, res_addr_nxt;
  ffha_pkg::status_t          res_st_r, res_st_nxt;
  logic [ffha_pkg::PAGES_W-1:0] res_pg_r, res_pg_nxt;
  logic                       ov_r, ov_nxt;
  logic [AW-1:0]              oaddr_r, oaddr_nxt;
  logic [1:0]                 ost_r, ost_nxt;
  logic [ffha_pkg::PAGES_W-1:0] opg_r, opg_nxt;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;
  ffha_pkg::ent_t      mem_wdata, mem_rdata;

  ffha_table #(.DEPTH(MAX_BLOCKS), .IDX_W(IDX_W)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // shared conditions
  logic [SW:0]                rq_up;
  logic                       in_acc;
  logic                       at_end;
  logic [ffha_pkg::ACC_W-1:0] payload_a;
  logic [ffha_pkg::ACC_W-1:0] app_end;
  logic                       fits, split_ok;
  ffha_pkg::ent_t             ment;
  logic [SW+1:0]              msum;
  logic                       mrg_ok;
  logic                       fin_go;
  logic [ffha_pkg::DIV_W-1:0] pg_q;
  logic [ffha_pkg::DIV_W-1:0] grown;

  assign in_acc    = in_valid && (state_r == ffha_pkg::S_IDLE);
  assign rq_up     = ({1'b0, in_request_bytes} + (SW+1)'(3)) & ~(SW+1)'(3);
  assign at_end    = (idx_r == count_r);
  assign payload_a = acc_r + HDR_A;
  assign app_end   = acc_r + HDR_A + ffha_pkg::ACC_W'(need_r);
  assign fits      = mem_rdata.free && (mem_rdata.size >= need_r);
  assign split_ok  = ({2'b0, mem_rdata.size} >= ({2'b0, need_r} + HDR_S + (SW+2)'(4)))
                     && (count_r < CNT_MAX);
  always_comb begin
    ment = mem_rdata;
    if (idx_r == hit_r) begin
      ment.free = 1'b1;
    end
  end
  assign msum    = {2'b0, held_r.size} + HDR_S + {2'b0, ment.size};
  assign mrg_ok  = held_r.free && ment.free && (msum <= MAX32);
  assign fin_go  = !ov_r || !out_stall;
  assign pg_q    = nq_r >> PG_SH;
  assign grown   = ffha_pkg::DIV_W'(limit_r) + (nq_r & ~PG_LOW);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffha_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_op == ffha_pkg::OP_ALLOC) begin
            if (in_request_bytes == '0 || rq_up[SW]) state_nxt = ffha_pkg::S_FIN;
            else state_nxt = ffha_pkg::S_A_SCAN_RD;
          end else begin
            if (in_payload_address == '0) state_nxt = ffha_pkg::S_FIN;
            else state_nxt = ffha_pkg::S_F_SCAN_RD;
          end
        end
      end
      ffha_pkg::S_A_SCAN_RD: begin
        if (!at_end) state_nxt = ffha_pkg::S_A_SCAN_EV;
        else if (count_r >= CNT_MAX) state_nxt = ffha_pkg::S_FIN;
        else state_nxt = ffha_pkg::S_A_APPEND;
      end
      ffha_pkg::S_A_SCAN_EV: begin
        if (fits) state_nxt = split_ok ? ffha_pkg::S_A_SHIFT_RD : ffha_pkg::S_FIN;
        else state_nxt = ffha_pkg::S_A_SCAN_RD;
      end
      ffha_pkg::S_A_SHIFT_RD: begin
        if (idx_r == hit_r + CNT_W'(1)) state_nxt = ffha_pkg::S_A_SPLIT;
        else state_nxt = ffha_pkg::S_A_SHIFT_EV;
      end
      ffha_pkg::S_A_SHIFT_EV: state_nxt = ffha_pkg::S_A_SHIFT_RD;
      ffha_pkg::S_A_SPLIT:    state_nxt = ffha_pkg::S_A_SPLIT2;
      ffha_pkg::S_A_SPLIT2:   state_nxt = ffha_pkg::S_FIN;
      ffha_pkg::S_A_APPEND:   state_nxt = ffha_pkg::S_FIN;
      ffha_pkg::S_F_SCAN_RD: begin
        if (at_end) state_nxt = ffha_pkg::S_FIN;
        else if (payload_a[AW-1:0] == faddr_r) state_nxt = ffha_pkg::S_F_MRG_RD;
        else state_nxt = ffha_pkg::S_F_SCAN_EV;
      end
      ffha_pkg::S_F_SCAN_EV:  state_nxt = ffha_pkg::S_F_SCAN_RD;
      ffha_pkg::S_F_MRG_RD: begin
        state_nxt = at_end ? ffha_pkg::S_F_MRG_END : ffha_pkg::S_F_MRG_EV;
      end
      ffha_pkg::S_F_MRG_EV:   state_nxt = ffha_pkg::S_F_MRG_RD;
      ffha_pkg::S_F_MRG_END:  state_nxt = ffha_pkg::S_FIN;
      ffha_pkg::S_FIN: begin
        if (fin_go) state_nxt = ffha_pkg::S_IDLE;
      end
      default: state_nxt = ffha_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    base_nxt     = base_r;
    limit_nxt    = limit_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    hit_nxt      = hit_r;
    wp_nxt       = wp_r;
    acc_nxt      = acc_r;
    need_nxt     = need_r;
    have_nxt     = have_r;
    faddr_nxt    = faddr_r;
    held_nxt     = held_r;
    hv_nxt       = hv_r;
    grow_nxt     = grow_r;
    nq_nxt       = nq_r;
    res_addr_nxt = res_addr_r;
    res_st_nxt   = res_st_r;
    res_pg_nxt   = res_pg_r;
    ov_nxt       = ov_r && out_stall;
    oaddr_nxt    = oaddr_r;
    ost_nxt      = ost_r;
    opg_nxt      = opg_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = idx_r[IDX_W-1:0];

    if (psel && penable && pwrite && paddr == ffha_pkg::ADDR_HEAP_BASE) begin
      base_nxt = pwdata[AW-1:0];
    end

    case (state_r)
      ffha_pkg::S_IDLE: begin
        idx_nxt      = '0;
        acc_nxt      = ffha_pkg::ACC_W'(base_r);
        need_nxt     = rq_up[SW-1:0];
        faddr_nxt    = in_payload_address;
        res_addr_nxt = '0;
        res_pg_nxt   = '0;
        res_st_nxt   = ffha_pkg::ST_OK;
        grow_nxt     = 1'b0;
        hv_nxt       = 1'b0;
        wp_nxt       = '0;
        if (in_op == ffha_pkg::OP_ALLOC) begin
          if (in_request_bytes == '0) res_st_nxt = ffha_pkg::ST_ZERO;
          else if (rq_up[SW]) res_st_nxt = ffha_pkg::ST_FULL;
        end else if (in_payload_address == '0) begin
          res_st_nxt = ffha_pkg::ST_ZERO;
        end
      end
      ffha_pkg::S_A_SCAN_RD: begin
        if (at_end) begin
          if (count_r >= CNT_MAX) begin
            res_st_nxt = ffha_pkg::ST_FULL;
          end else if (app_end > {2'b0, limit_r}) begin
            // shortfall plus page - 1, whole pages taken by the shift
            grow_nxt  = 1'b1;
            nq_nxt    = ffha_pkg::DIV_W'(app_end) - ffha_pkg::DIV_W'(limit_r) + PG_LOW;
          end
        end
      end
      ffha_pkg::S_A_SCAN_EV: begin
        if (fits) begin
          hit_nxt      = idx_r;
          have_nxt     = mem_rdata.size;
          res_addr_nxt = payload_a[AW-1:0];
          if (split_ok) begin
            idx_nxt = count_r;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = idx_r[IDX_W-1:0];
            mem_wdata = '{free: 1'b0, size: mem_rdata.size};
          end
        end else begin
          acc_nxt = acc_r + HDR_A + ffha_pkg::ACC_W'(mem_rdata.size);
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ffha_pkg::S_A_SHIFT_RD: begin
        mem_raddr = IDX_W'(idx_r - CNT_W'(1));
      end
      ffha_pkg::S_A_SHIFT_EV: begin
        // writes land above the read pointer, no overlap
        mem_we    = 1'b1;
        mem_waddr = idx_r[IDX_W-1:0];
        mem_wdata = mem_rdata;
        idx_nxt   = idx_r - CNT_W'(1);
      end
      ffha_pkg::S_A_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(hit_r + CNT_W'(1));
        mem_wdata = '{free: 1'b1, size: have_r - need_r - SW'(HEADER_BYTES)};
      end
      ffha_pkg::S_A_SPLIT2: begin
        mem_we    = 1'b1;
        mem_waddr = hit_r[IDX_W-1:0];
        mem_wdata = '{free: 1'b0, size: need_r};
        count_nxt = count_r + CNT_W'(1);
      end
      ffha_pkg::S_A_APPEND: begin
        mem_we       = 1'b1;
        mem_waddr    = count_r[IDX_W-1:0];
        mem_wdata    = '{free: 1'b0, size: need_r};
        count_nxt    = count_r + CNT_W'(1);
        res_addr_nxt = payload_a[AW-1:0];
        if (grow_r) begin
          limit_nxt  = grown[AW-1:0];
          res_pg_nxt = (pg_q > ffha_pkg::DIV_W'(ffha_pkg::PAGES_SAT)) ?
                       ffha_pkg::PAGES_SAT : pg_q[ffha_pkg::PAGES_W-1:0];
        end
      end
      ffha_pkg::S_F_SCAN_RD: begin
        if (at_end) begin
          res_st_nxt = ffha_pkg::ST_UNKNOWN;
        end else if (payload_a[AW-1:0] == faddr_r) begin
          hit_nxt = idx_r;
          idx_nxt = '0;
        end
      end
      ffha_pkg::S_F_SCAN_EV: begin
        acc_nxt = acc_r + HDR_A + ffha_pkg::ACC_W'(mem_rdata.size);
        idx_nxt = idx_r + CNT_W'(1);
      end
      ffha_pkg::S_F_MRG_EV: begin
        // compaction: the freed entry is marked on the fly, writes trail the reads
        idx_nxt = idx_r + CNT_W'(1);
        hv_nxt  = 1'b1;
        if (!hv_r) begin
          held_nxt = ment;
        end else if (mrg_ok) begin
          held_nxt.size = msum[SW-1:0];
        end else begin
          mem_we    = 1'b1;
          mem_waddr = wp_r[IDX_W-1:0];
          mem_wdata = held_r;
          wp_nxt    = wp_r + CNT_W'(1);
          held_nxt  = ment;
        end
      end
      ffha_pkg::S_F_MRG_END: begin
        mem_we    = 1'b1;
        mem_waddr = wp_r[IDX_W-1:0];
        mem_wdata = held_r;
        count_nxt = wp_r + CNT_W'(1);
      end
      ffha_pkg::S_FIN: begin
        if (fin_go) begin
          ov_nxt    = 1'b1;
          oaddr_nxt = res_addr_r;
          ost_nxt   = res_st_r;
          opg_nxt   = res_pg_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffha_pkg::S_IDLE;
      base_r  <= ffha_pkg::HEAP_BASE_RST;
      limit_r <= ffha_pkg::HEAP_BASE_RST;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      limit_r <= limit_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    wp_r       <= wp_nxt;
    acc_r      <= acc_nxt;
    need_r     <= need_nxt;
    have_r     <= have_nxt;
    faddr_r    <= faddr_nxt;
    held_r     <= held_nxt;
    hv_r       <= hv_nxt;
    grow_r     <= grow_nxt;
    nq_r       <= nq_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    res_pg_r   <= res_pg_nxt;
    oaddr_r    <= oaddr_nxt;
    ost_r      <= ost_nxt;
    opg_r      <= opg_nxt;
  end

  assign in_stall          = (state_r != ffha_pkg::S_IDLE);
  assign out_valid         = ov_r;
  assign out_block_address = oaddr_r;
  assign out_status        = ost_r;
  assign out_pages_added   = opg_r;
  assign pready            = 1'b1;
  assign prdata            = (paddr == ffha_pkg::ADDR_HEAP_BASE) ?
                             ffha_pkg::PDATA_W'(base_r) : '0;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("block count beyond table depth");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffha_pkg::S_IDLE) |=> (count_r == $past(count_r)))
    else $error("block count changed with no transaction in progress");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ost_r != ffha_pkg::ST_OK) |-> (oaddr_r == '0 && opg_r == '0))
    else $error("refused transaction carries an address or page count");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ffha_pkg::S_IDLE))
    else $error("accepted transaction did not start");
`endif

endmodule
`default_nettype wire

@@ verif/ffha_checker.sv @@
// checker for first_fit_heap_allocator: watches the request, result and register ports,
// keeps its own model of the block table and compares every result transaction
// depends on ffha_pkg for widths and status codes
`default_nettype none
module ffha_checker (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  input  wire                           in_stall,
  input  wire                           in_op,
  input  wire [31:0]                    in_request_bytes,
  input  wire [ffha_pkg::ADDR_W-1:0]    in_payload_address,
  input  wire                           out_valid,
  input  wire                           out_stall,
  input  wire [ffha_pkg::ADDR_W-1:0]    out_block_address,
  input  wire [1:0]                     out_status,
  input  wire [ffha_pkg::PAGES_W-1:0]   out_pages_added,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire                           pready,
  input  wire [ffha_pkg::PADDR_W-1:0]   paddr,
  input  wire [ffha_pkg::PDATA_W-1:0]   pwdata,
  output int                            fail_count,
  output int                            results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          AW     = ffha_pkg::ADDR_W;
  localparam int          PW     = ffha_pkg::PAGES_W;
  localparam int          NBLK   = 64;
  localparam logic [63:0] HDR    = 64'd24;
  localparam logic [63:0] PAGE   = 64'd4096;
  localparam logic [63:0] AMASK  = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] SZMAX  = 64'hFFFF_FFFF;

  typedef struct {
    logic [AW-1:0]      addr;
    ffha_pkg::status_t  status;
    logic [PW-1:0]      pages;
  } alloc_result_t;

  alloc_result_t expected_results[$];
  logic [63:0]   heap_base_m, heap_limit_m;
  logic [31:0]   blk_size[NBLK];
  bit            blk_free[NBLK];
  int            blk_count;

  assign results_pending = expected_results.size();

  function automatic logic [63:0] header_addr(int idx);
    logic [63:0] a;
    a = heap_base_m;
    for (int k = 0; k < idx && k < NBLK; k++) a += HDR + blk_size[k];
    return a;
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < blk_count; k++) begin
      blk_size[k] = blk_size[k+1];
      blk_free[k] = blk_free[k+1];
    end
    blk_count--;
  endfunction

  function automatic void add_entry(int idx, logic [31:0] sz, bit fr);
    for (int k = blk_count; k > idx; k--) begin
      blk_size[k] = blk_size[k-1];
      blk_free[k] = blk_free[k-1];
    end
    blk_size[idx] = sz;
    blk_free[idx] = fr;
    blk_count++;
  endfunction

  function automatic alloc_result_t run_allocate(logic [31:0] req);
    alloc_result_t r;
    logic [63:0] need, have, start_a, end_a, pages;
    r.addr = '0; r.status = ffha_pkg::ST_OK; r.pages = '0;
    if (req == 0) begin
      r.status = ffha_pkg::ST_ZERO;
      return r;
    end
    need = ({32'd0, req} + 64'd3) & ~64'd3;
    if (need > SZMAX) begin
      r.status = ffha_pkg::ST_FULL;
      return r;
    end
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && {32'd0, blk_size[i]} >= need) begin
        have = {32'd0, blk_size[i]};
        if (have >= need + HDR + 64'd4 && blk_count < NBLK) begin
          add_entry(i + 1, 32'(have - need - HDR), 1'b1);
          blk_size[i] = 32'(need);
        end
        blk_free[i] = 1'b0;
        r.addr = AW'(header_addr(i) + HDR);
        return r;
      end
    end
    if (blk_count >= NBLK) begin
      r.status = ffha_pkg::ST_FULL;
      return r;
    end
    start_a = header_addr(blk_count);
    end_a = start_a + HDR + need;
    pages = 0;
    if (end_a > heap_limit_m) begin
      pages = (end_a - heap_limit_m + PAGE - 64'd1) / PAGE;
      heap_limit_m = (heap_limit_m + pages * PAGE) & AMASK;
    end
    add_entry(blk_count, 32'(need), 1'b0);
    r.addr = AW'(start_a + HDR);
    r.pages = (pages > 64'd1048576) ? ffha_pkg::PAGES_SAT : PW'(pages);
    return r;
  endfunction

  function automatic alloc_result_t run_free(logic [AW-1:0] pa);
    alloc_result_t r;
    int i;
    logic [63:0] merged;
    bit found;
    r.addr = '0; r.status = ffha_pkg::ST_OK; r.pages = '0;
    found = 0;
    if (pa == 0) begin
      r.status = ffha_pkg::ST_ZERO;
      return r;
    end
    for (i = 0; i < blk_count; i++) begin
      if (((header_addr(i) + HDR) & AMASK) == {16'd0, pa}) begin
        found = 1;
        break;
      end
    end
    if (!found) begin
      r.status = ffha_pkg::ST_UNKNOWN;
      return r;
    end
    blk_free[i] = 1'b1;
    i = 0;
    while (i + 1 < blk_count) begin
      merged = {32'd0, blk_size[i]} + HDR + {32'd0, blk_size[i+1]};
      if (blk_free[i] && blk_free[i+1] && merged <= SZMAX) begin
        blk_size[i] = 32'(merged);
        drop_entry(i + 1);
      end else begin
        i++;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst_n) begin
      heap_base_m  = {16'd0, ffha_pkg::HEAP_BASE_RST};
      heap_limit_m = {16'd0, ffha_pkg::HEAP_BASE_RST};
      blk_count    = 0;
      expected_results.delete();
      fail_count   = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ffha_pkg::ADDR_HEAP_BASE)
        heap_base_m = pwdata & AMASK;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result transaction addr=%h status=%0d pages=%0d",
                     $realtime, out_block_address, out_status, out_pages_added);
        end else begin
          e = expected_results.pop_front();
          if (out_block_address !== e.addr || out_status !== e.status ||
              out_pages_added !== e.pages) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp addr=%h status=%0d pages=%0d, %s=%h %s=%0d %s=%0d",
                       $realtime, e.addr, e.status, e.pages,
                       "got addr", out_block_address, "status", out_status,
                       "pages", out_pages_added);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_op == ffha_pkg::OP_ALLOC) e = run_allocate(in_request_bytes);
        else                             e = run_free(in_payload_address);
        expected_results.push_back(e);
      end
    end
  end

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// top of the first_fit_heap_allocator testbench: clock, reset, request stimulus,
// register writes and result-side stall; depends on ffha_pkg, first_fit_heap_allocator and ffha_checker
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW          = ffha_pkg::ADDR_W;
  localparam int IDLE_WAIT   = 400;
  localparam int STALL_LIMIT = 5000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_op = ffha_pkg::OP_ALLOC;
  logic [31:0]         in_request_bytes = '0;
  logic [AW-1:0]       in_payload_address = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [AW-1:0]       out_block_address;
  logic [1:0]          out_status;
  logic [ffha_pkg::PAGES_W-1:0] out_pages_added;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ffha_pkg::PADDR_W-1:0] paddr = '0;
  logic [ffha_pkg::PDATA_W-1:0] pwdata = '0;
  logic [ffha_pkg::PDATA_W-1:0] prdata;
  logic                pready;

  int  fail_count, results_pending;
  bit  quiet = 0;
  bit  in_taken = 0;
  int  gap_left = 0, stall_left = 0, idle_cycles = 0;
  logic [AW-1:0] live_blocks[$];

  always #6 clk = ~clk;

  first_fit_heap_allocator i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_request_bytes, .in_payload_address,
    .out_valid, .out_stall, .out_block_address, .out_status, .out_pages_added,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ffha_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_request_bytes, .in_payload_address,
    .out_valid, .out_stall, .out_block_address, .out_status, .out_pages_added,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .results_pending
  );

  // transaction tracking sampled on the rising edge, before the block updates
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall && out_block_address != 0)
      live_blocks.push_back(out_block_address);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result-side back-pressure in bursts
  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(logic op, logic [31:0] req, logic [AW-1:0] pa);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap_left = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap_left) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_request_bytes <= req;
    in_payload_address <= pa;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  task automatic write_heap_base(logic [AW-1:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ffha_pkg::ADDR_HEAP_BASE; pwdata <= {16'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic free_live(bit keep);
    int k;
    logic [AW-1:0] a;
    k = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[k];
    if (!keep) live_blocks.delete(k);
    send_request(ffha_pkg::OP_FREE, '0, a);
  endtask

  task automatic random_phase(int n);
    int r;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 52)
        send_request(ffha_pkg::OP_ALLOC, $urandom_range(1, 300), AW'({$urandom, $urandom}));
      else if (r < 56)
        send_request(ffha_pkg::OP_ALLOC, $urandom_range(301, 9000),
                     AW'({$urandom, $urandom}));
      else if (r < 58)
        send_request(ffha_pkg::OP_ALLOC, $urandom, AW'({$urandom, $urandom}));
      else if (r < 59)
        send_request(ffha_pkg::OP_ALLOC, 32'd0, AW'({$urandom, $urandom}));
      else if (r < 92 && live_blocks.size() > 0)
        free_live(r >= 89);
      else if (r < 97)
        send_request(ffha_pkg::OP_FREE, $urandom, AW'({$urandom, $urandom}));
      else
        send_request(ffha_pkg::OP_FREE, $urandom, '0);
    end
    // release everything still held so the table coalesces before the next base
    while (live_blocks.size() > 0) free_live(0);
    wait_idle();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero size, tiny sizes, too large, page saturation, merge overflow
    send_request(ffha_pkg::OP_ALLOC, 32'd0, '0);
    send_request(ffha_pkg::OP_ALLOC, 32'd1, '1);
    send_request(ffha_pkg::OP_ALLOC, 32'd4, '0);
    send_request(ffha_pkg::OP_ALLOC, 32'd5, '0);
    send_request(ffha_pkg::OP_ALLOC, 32'hFFFF_FFFD, '0);
    send_request(ffha_pkg::OP_ALLOC, 32'hFFFF_FFFF, '0);
    send_request(ffha_pkg::OP_FREE, '1, '0);
    send_request(ffha_pkg::OP_FREE, '0, '1);
    send_request(ffha_pkg::OP_FREE, '1, 48'h0000_4000_0018);
    send_request(ffha_pkg::OP_FREE, '0, 48'h0000_4000_0018);
    send_request(ffha_pkg::OP_ALLOC, 32'd200, '0);
    send_request(ffha_pkg::OP_ALLOC, 32'hFFFF_FFFC, '0);
    send_request(ffha_pkg::OP_ALLOC, 32'hFFFF_FFFC, '0);
    wait_idle();
    while (live_blocks.size() > 0) free_live(0);
    send_request(ffha_pkg::OP_ALLOC, 32'd3, '0);
    send_request(ffha_pkg::OP_ALLOC, 32'd100, '0);
    send_request(ffha_pkg::OP_ALLOC, 32'hFFFF_FFF0, '0);
    wait_idle();
    while (live_blocks.size() > 0) free_live(0);
    wait_idle();

    random_phase(290);
    write_heap_base('0);
    random_phase(260);
    write_heap_base(48'hFFFF_FFFF_FF00);
    random_phase(240);
    write_heap_base(48'hFFFF_FFFF_FFFF);
    random_phase(120);
    write_heap_base(AW'({$urandom, $urandom}));
    random_phase(200);
    write_heap_base(ffha_pkg::HEAP_BASE_RST);
    quiet = 1;
    random_phase(200);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ first_fit_heap_allocator.f @@
hdl/ffha_pkg.sv
hdl/ffha_table.sv
hdl/first_fit_heap_allocator.sv
verif/ffha_checker.sv
verif/testbench.sv
